// ----- design/cbrw_pkg.sv -----
// Package for the counter-based random word generator.
// Holds the round constants, the lane type passed between round cells and defaults.
// No dependencies.
package cbrw_pkg;

   localparam int unsigned WORD_WIDTH     = 32;
   localparam int unsigned KEY_WIDTH      = 64;
   localparam int unsigned INDEX_WIDTH    = 64;
   localparam int unsigned SEL_WIDTH      = 2;
   localparam int unsigned LANE_WORDS     = 4;
   localparam int unsigned ROUND_COUNT_DEF = 10;

   // Multiplier and key-bump constants of the round function
   localparam logic [WORD_WIDTH-1:0] MUL_A  = 32'hD251_1F53;
   localparam logic [WORD_WIDTH-1:0] MUL_B  = 32'hCD9E_8D57;
   localparam logic [WORD_WIDTH-1:0] BUMP_A = 32'h9E37_79B9;
   localparam logic [WORD_WIDTH-1:0] BUMP_B = 32'hBB67_AE85;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // Data handed from one round cell to the next
   typedef struct packed {
      word_type [LANE_WORDS-1:0] w;    // counter block words
      word_type                  k0;   // key word zero for this round
      word_type                  k1;   // key word one for this round
      logic [SEL_WIDTH-1:0]      sel;  // output word pick
   } lane_type;

endpackage

// ----- design/cbrw_round_cell.sv -----
// One round cell: both 32x32 products registered, then exchange/XOR and key bump.
// Depends on cbrw_pkg.
module cbrw_round_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              vld_in,
   input  cbrw_pkg::lane_type lane_in,
   output logic              vld_out,
   output cbrw_pkg::lane_type lane_out
);
   import cbrw_pkg::*;

   logic [2*WORD_WIDTH-1:0] prod_a_in, prod_b_in;
   logic [2*WORD_WIDTH-1:0] prod_a_ff, prod_b_ff;
   word_type                w1_ff, w3_ff, k0_ff, k1_ff;
   logic [SEL_WIDTH-1:0]    sel_ff;
   logic                    vld_ff;

   // Products of words zero and two
   assign prod_a_in = {{WORD_WIDTH{1'b0}}, MUL_A} * {{WORD_WIDTH{1'b0}}, lane_in.w[0]};
   assign prod_b_in = {{WORD_WIDTH{1'b0}}, MUL_B} * {{WORD_WIDTH{1'b0}}, lane_in.w[2]};

   // Payload stage
   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      w1_ff     <= lane_in.w[1];
      w3_ff     <= lane_in.w[3];
      k0_ff     <= lane_in.k0;
      k1_ff     <= lane_in.k1;
      sel_ff    <= lane_in.sel;
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Exchange, XOR with key, bump key for the next cell
   always_comb begin
      lane_out.w[0] = prod_b_ff[2*WORD_WIDTH-1:WORD_WIDTH] ^ w1_ff ^ k0_ff;
      lane_out.w[1] = prod_b_ff[WORD_WIDTH-1:0];
      lane_out.w[2] = prod_a_ff[2*WORD_WIDTH-1:WORD_WIDTH] ^ w3_ff ^ k1_ff;
      lane_out.w[3] = prod_a_ff[WORD_WIDTH-1:0];
      lane_out.k0   = k0_ff + BUMP_A;
      lane_out.k1   = k1_ff + BUMP_B;
      lane_out.sel  = sel_ff;
   end

   assign vld_out = vld_ff;

endmodule

// ----- design/counter_based_random_word.sv -----
// Counter-based random word generator, Philox 4x32 style, one round cell per round.
// An accepted request passes the register of every round cell, then the output register;
// rsp_valid and rsp_random_word both come from that output register.
// Throughput: one request per cycle while busy is low; each round cell holds one 32x32 multiply stage.
// busy is high only while reset is asserted; the receiver cannot stall results.
// Reset clears the key to zero and drops every transfer in flight.
// Depends on cbrw_pkg and cbrw_round_cell.
module counter_based_random_word #(
   parameter int unsigned ROUND_COUNT = cbrw_pkg::ROUND_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [cbrw_pkg::INDEX_WIDTH-1:0]     req_sample_index,
   output logic                                 rsp_valid,
   output logic [cbrw_pkg::WORD_WIDTH-1:0]      rsp_random_word,
   input  logic                                 csr_wr_en,
   input  logic [cbrw_pkg::KEY_WIDTH-1:0]       csr_key_seed
);
   import cbrw_pkg::*;

   logic [KEY_WIDTH-1:0]  key_ff;
   lane_type              lane [ROUND_COUNT+1];
   logic                  vld  [ROUND_COUNT+1];
   logic                  accept;
   word_type              rsp_word_in, rsp_word_ff;
   logic                  rsp_valid_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // Key register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff <= csr_key_seed;
      end
   end

   // Head of the chain: block counter from the index, upper counter words zero
   always_comb begin
      lane[0].w[0] = req_sample_index[WORD_WIDTH+1:2];
      lane[0].w[1] = {2'b00, req_sample_index[INDEX_WIDTH-1:WORD_WIDTH+2]};
      lane[0].w[2] = '0;
      lane[0].w[3] = '0;
      lane[0].k0   = key_ff[WORD_WIDTH-1:0];
      lane[0].k1   = key_ff[KEY_WIDTH-1:WORD_WIDTH];
      lane[0].sel  = req_sample_index[SEL_WIDTH-1:0];
      vld[0]       = accept;
   end

   // Row of round cells
   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      cbrw_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .vld_in   (vld[r]),
         .lane_in  (lane[r]),
         .vld_out  (vld[r+1]),
         .lane_out (lane[r+1])
      );
   end

   // Word pick and output register
   assign rsp_word_in = lane[ROUND_COUNT].w[lane[ROUND_COUNT].sel];

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld[ROUND_COUNT];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   // Every result strobe traces back to an accepted transfer
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, ROUND_COUNT+1))
      else $error("result strobe without matching request");

   // Every accepted transfer yields a result
   a_req_gets_rsp : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(ROUND_COUNT+1) rsp_valid)
      else $error("accepted request produced no result");

   // Nothing is taken while reset holds the block busy
   a_no_accept_in_reset : assert property (@(posedge clock)
      reset |-> !accept)
      else $error("transfer accepted during reset");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for counter_based_random_word: a directed table of sample indexes, then random ones,
// under several keys; each result checked against a table word or the bench's Philox 4x32 model.
// Depends on cbrw_pkg and the counter_based_random_word RTL.
module tb;
   import cbrw_pkg::*;

   localparam int unsigned ROUNDS      = ROUND_COUNT_DEF;
   localparam int unsigned LATENCY     = ROUNDS + 1;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 50;

   typedef enum logic {ROW_KEY, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [63:0]           value;     // key for ROW_KEY, sample index for ROW_SAMPLE
      logic                  has_word;  // expected word given in the row
      word_type              word;
   } stim_row_type;

   // Zero key, zero counter gives the published Philox 4x32-10 block
   localparam stim_row_type DIRECTED_ROWS [0:26] = '{
      '{ROW_SAMPLE, 64'h0000_0000_0000_0000, 1'b1, 32'h6627_e8d5},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0001, 1'b1, 32'he169_c58d},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0002, 1'b1, 32'hbc57_ac4c},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0003, 1'b1, 32'h9b00_dbd8},
      '{ROW_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0003_FFFF_FFFC, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0004_0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h5555_5555_5555_5555, 1'b0, 32'h0},
      '{ROW_KEY,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0003, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h5555_5555_5555_5555, 1'b0, 32'h0},
      '{ROW_KEY,    64'h0000_0000_FFFF_FFFF, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0001, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h8000_0000_0000_0002, 1'b0, 32'h0},
      '{ROW_KEY,    64'hFFFF_FFFF_0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0002, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
      '{ROW_KEY,    64'h0123_4567_89AB_CDEF, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0000, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0001, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0002, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'h0000_0000_0000_0003, 1'b0, 32'h0},
      '{ROW_SAMPLE, 64'hFEDC_BA98_7654_3210, 1'b0, 32'h0}
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [INDEX_WIDTH-1:0] req_sample_index;
   logic                   rsp_valid;
   word_type               rsp_random_word;
   logic                   csr_wr_en;
   logic [KEY_WIDTH-1:0]   csr_key_seed;

   // Expected word handed from the driver with the transfer, when the table gives one
   logic                   given_valid;
   word_type               given_word;

   logic [KEY_WIDTH-1:0]   key_now;
   word_type               pending_words [$];
   int unsigned            error_count;
   int unsigned            quiet_cycles;
   int unsigned            idle_pct;

   counter_based_random_word #(
      .ROUND_COUNT(ROUNDS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_random_word  (rsp_random_word),
      .csr_wr_en        (csr_wr_en),
      .csr_key_seed     (csr_key_seed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Philox 4x32: counter {idx>>2, 0, 0}, ROUNDS rounds, word picked by idx[1:0]
   function automatic word_type philox_word_at(input logic [63:0] key, input logic [63:0] idx);
      word_type    w [LANE_WORDS];
      word_type    k0, k1, n0, n2;
      logic [63:0] blk, p0, p2;
      blk  = idx >> 2;
      w[0] = blk[31:0];
      w[1] = blk[63:32];
      w[2] = '0;
      w[3] = '0;
      k0   = key[31:0];
      k1   = key[63:32];
      for (int r = 0; r < ROUNDS; r++) begin
         p0   = {32'd0, MUL_A} * {32'd0, w[0]};
         p2   = {32'd0, MUL_B} * {32'd0, w[2]};
         n0   = p2[63:32] ^ w[1] ^ k0;
         n2   = p0[63:32] ^ w[3] ^ k1;
         w[0] = n0;
         w[1] = p2[31:0];
         w[2] = n2;
         w[3] = p0[31:0];
         k0   = k0 + BUMP_A;
         k1   = k1 + BUMP_B;
      end
      return w[idx[1:0]];
   endfunction

   // Monitor: check results, track the key, queue the expected word per transfer
   always @(posedge clock) begin
      if (reset) begin
         key_now      = '0;
         quiet_cycles = quiet_cycles + 1;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (rsp_valid) begin
            quiet_cycles = 0;
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_random_word);
               error_count = error_count + 1;
            end else if (pending_words[0] !== rsp_random_word) begin
               $display("%0t: random_word mismatch, expected %h, actual %h",
                        $time, pending_words[0], rsp_random_word);
               error_count = error_count + 1;
               void'(pending_words.pop_front());
            end else begin
               void'(pending_words.pop_front());
            end
         end
         if (csr_wr_en) begin
            key_now      = csr_key_seed;
            quiet_cycles = 0;
         end
         if (start && !busy) begin
            quiet_cycles = 0;
            if (given_valid)
               pending_words = {pending_words, given_word};
            else
               pending_words = {pending_words, philox_word_at(key_now, req_sample_index)};
         end
      end
   end

   // One sample index transfer, with random idle cycles ahead of it
   task automatic send_index(input logic [63:0] idx, input logic has_word, input word_type word);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_sample_index <= idx;
      given_valid      <= has_word;
      given_word       <= word;
      do @(posedge clock); while (busy);
   endtask

   // Key write once the pipeline has drained
   task automatic write_key(input logic [63:0] key);
      @(negedge clock);
      start <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      csr_wr_en    <= 1'b1;
      csr_key_seed <= key;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   // Watchdog: end the run when nothing has moved for too long
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb: done, errors");
      $finish;
   end

   // Stimulus
   initial begin
      logic [63:0] idx;
      logic [63:0] key;
      reset            = 1'b1;
      start            = 1'b0;
      req_sample_index = '0;
      csr_wr_en        = 1'b0;
      csr_key_seed     = '0;
      given_valid      = 1'b0;
      given_word       = '0;
      key_now          = '0;
      error_count      = 0;
      quiet_cycles     = 0;
      idle_pct         = 32;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, starting from the reset key
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_KEY)
            write_key(DIRECTED_ROWS[i].value);
         else
            send_index(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].has_word,
                       DIRECTED_ROWS[i].word);
      end

      // Random phases: extreme keys first, then random ones; one phase without idling
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0)
            key = '1;
         else if (phase == 1)
            key = '0;
         else
            key = {$urandom, $urandom};
         write_key(key);
         idle_pct = (phase == 3) ? 0 : 32;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            idx = {$urandom, $urandom};
            case ($urandom_range(3))
               0:       ;                              // anywhere
               1:       idx = {58'd0, idx[5:0]};       // first few blocks
               2:       idx[63:32] = 32'hFFFF_FFFF;    // top of the range
               default: idx = {30'd0, idx[33:0]};      // counter word one zero
            endcase
            send_index(idx, 1'b0, '0);
         end
      end
      @(negedge clock);
      start <= 1'b0;

      // Drain, then watch for stray results
      while (pending_words.size() != 0) @(negedge clock);
      repeat (2 * LATENCY) @(negedge clock);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ----- counter_based_random_word.f -----
design/cbrw_pkg.sv
design/cbrw_round_cell.sv
design/counter_based_random_word.sv
tb/sv/tb.sv
